>>> rtl/msma_pkg.sv
// Shared types and constants of the moisture scaling moving-average block.
package msma_pkg;

   // Field widths
   localparam int RAW_W     = 10;
   localparam int PCT_W     = 7;
   localparam int SUM_W     = 10;
   localparam int CSR_IDX_W = 2;

   // Scaling and saturation constants
   localparam int PctFull   = 100;
   localparam int SumMax    = 1023;
   localparam int WINDOW_DEF = 10;
   localparam int DryReset  = 600;
   localparam int WetReset  = 300;

   // Divider: dividend is a 10-bit magnitude times 100, which needs 17 bits
   localparam int QUO_W     = 17;
   localparam int DivSteps  = QUO_W;
   localparam int CNT_W     = 5;

   // Request stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DRY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WET = 2'd1;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic step;
      logic commit;
   } msma_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;
   } msma_status_type;

endpackage

>>> rtl/msma_ctrl.sv
// Controller state machine: sequences load, divide steps and commit of one request.
module msma_ctrl
   import msma_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  msma_status_type status,
   output msma_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Decode commands from the current state
   assign req_tready = (state_ff == ST_IDLE);
   assign cmd.load   = (state_ff == ST_IDLE) && req_tvalid;
   assign cmd.step   = (state_ff == ST_DIV);
   assign cmd.commit = (state_ff == ST_FINISH) && status.out_free;

   // Next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_tvalid) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DivSteps - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and step count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in flight");
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff <= CNT_W'(DivSteps - 1)))
      else $error("divide step count out of range");
   a_full_divide: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> ##(DivSteps) (state_ff == ST_FINISH))
      else $error("divide did not run all steps");
`endif

endmodule

>>> rtl/msma_dpath.sv
// Datapath: calibration registers, scaling divider, sample ring, total and result register.
module msma_dpath
   import msma_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [RAW_W-1:0]      csr_data,
   input  logic [RAW_W-1:0]      raw_sample,
   input  msma_cmd_type          cmd,
   output msma_status_type       status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PCT_W-1:0]      percent_now,
   output logic [SUM_W-1:0]      window_sum
);

   localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int TOT_MAX = WINDOW * PctFull;
   localparam int TOT_W   = $clog2(TOT_MAX + 1);
   localparam int SAT_W   = (TOT_W > SUM_W) ? TOT_W : SUM_W + 1;

   logic [RAW_W-1:0]  dry_ff, wet_ff;
   logic [QUO_W-1:0]  dvd_ff, dvd_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [RAW_W-1:0]  rem_ff, rem_in;
   logic [RAW_W-1:0]  den_ff;
   logic              den_zero_ff, mismatch_ff;
   logic [PCT_W-1:0]  old_ff;
   logic              old_vld_ff;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [WINDOW-1:0] valid_ff;
   logic [PCT_W-1:0]  ring_mem [WINDOW];
   logic              rsp_valid_ff;
   logic [PCT_W-1:0]  pct_out_ff;
   logic [SUM_W-1:0]  sum_out_ff;

   logic              num_neg, den_neg;
   logic [RAW_W-1:0]  num_mag, den_mag;
   logic [RAW_W:0]    rem_shift;
   logic              fits;
   logic [PCT_W-1:0]  pct_calc, old_val;
   logic [SAT_W-1:0]  tot_ext;
   logic [SUM_W-1:0]  sum_sat;

   // Write calibration registers; ignore unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         dry_ff <= RAW_W'(DryReset);
         wet_ff <= RAW_W'(WetReset);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_DRY: dry_ff <= csr_data;
            CSR_WET: wet_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Take magnitudes and signs of numerator and denominator
   always_comb begin
      num_neg = raw_sample < dry_ff;
      num_mag = num_neg ? (dry_ff - raw_sample) : (raw_sample - dry_ff);
      den_neg = wet_ff < dry_ff;
      den_mag = den_neg ? (dry_ff - wet_ff) : (wet_ff - dry_ff);
   end

   // One restoring divide step
   always_comb begin
      rem_shift = {rem_ff, dvd_ff[QUO_W-1]};
      fits      = rem_shift >= {1'b0, den_ff};
      rem_in    = fits ? RAW_W'(rem_shift - {1'b0, den_ff}) : rem_shift[RAW_W-1:0];
      quo_in    = {quo_ff[QUO_W-2:0], fits};
      dvd_in    = {dvd_ff[QUO_W-2:0], 1'b0};
   end

   // Load operands or advance the divider
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dvd_ff      <= QUO_W'(num_mag) * QUO_W'(PctFull);
         quo_ff      <= '0;
         rem_ff      <= '0;
         den_ff      <= den_mag;
         den_zero_ff <= (den_mag == '0);
         mismatch_ff <= (num_neg != den_neg);
      end else if (cmd.step) begin
         dvd_ff <= dvd_in;
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   // Clamp the quotient to the percentage range; a zero span or opposite signs give zero
   always_comb begin
      if (den_zero_ff || mismatch_ff || (quo_ff == '0)) begin
         pct_calc = '0;
      end else if (quo_ff > QUO_W'(PctFull)) begin
         pct_calc = PCT_W'(PctFull);
      end else begin
         pct_calc = quo_ff[PCT_W-1:0];
      end
   end

   // Ring memory: read the slot on load, write it on commit
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         old_ff <= ring_mem[slot_ff];
      end
      if (cmd.commit) begin
         ring_mem[slot_ff] <= pct_calc;
      end
   end

   // Mark written entries; unwritten ones read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit) begin
         valid_ff[slot_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         old_vld_ff <= valid_ff[slot_ff];
      end
   end

   // Update running total and advance the slot
   always_comb begin
      old_val  = old_vld_ff ? old_ff : '0;
      total_in = total_ff - TOT_W'(old_val) + TOT_W'(pct_calc);
      slot_in  = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
      tot_ext  = SAT_W'(total_in);
      sum_sat  = (tot_ext > SAT_W'(SumMax)) ? SUM_W'(SumMax) : tot_ext[SUM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         slot_ff  <= '0;
      end else if (cmd.commit) begin
         total_ff <= total_in;
         slot_ff  <= slot_in;
      end
   end

   // Result register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         pct_out_ff <= pct_calc;
         sum_out_ff <= sum_sat;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign percent_now     = pct_out_ff;
   assign window_sum      = sum_out_ff;

`ifndef SYNTHESIS
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TOT_W'(TOT_MAX))
      else $error("running total exceeds window capacity");
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before taken");
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed result not presented");
`endif

endmodule

>>> rtl/moisture_scale_moving_average.sv
// Top level of the moisture scaling moving-average block.
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  req_tdata[9:0]  raw_sample
//  rsp      out        rsp_tvalid/rsp_tready  rsp_tdata[6:0]  percent_now, [16:7] window_sum
//  csr      in         csr_valid/csr_ready    csr_index, csr_data[9:0]
//
//  For each request the accepting edge loads the divider, the bit-serial restoring divider
//  then runs for the calibration map, and a commit writes the ring and the result register.
//  The result is registered at commit and held until taken.
//  The next request is accepted in the cycle after commit, while the result waits.
//  A stalled result delays only the commit of the following request.
//  Reset is synchronous; the ring clears at once through per-entry valid bits.
//  Configuration writes are taken in every cycle.
module moisture_scale_moving_average
   import msma_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [9:0] raw_sample
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [6:0] percent_now, [16:7] window_sum
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [RAW_W-1:0]       csr_data
);

   msma_cmd_type    cmd;
   msma_status_type status;
   logic [PCT_W-1:0] percent_now;
   logic [SUM_W-1:0] window_sum;

   // Accept configuration writes at any time
   assign csr_ready = 1'b1;

   msma_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   msma_dpath #(
      .WINDOW (WINDOW)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .raw_sample  (req_tdata[RAW_W-1:0]),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .percent_now (percent_now),
      .window_sum  (window_sum)
   );

   // Pack result fields, lowest first
   assign rsp_tdata = {{(RSP_DATA_W - PCT_W - SUM_W){1'b0}}, window_sum, percent_now};

endmodule

>>> verif/moisture_scale_moving_average_tb.sv
// Self-checking testbench for the moisture scaling moving-average block.
`timescale 1ns / 1ps

module moisture_scale_moving_average_tb;
   import msma_pkg::*;

   localparam int WINDOW     = WINDOW_DEF;
   localparam int IDLE_LIMIT = 3000;   // cycles with no accepted request on any channel
   localparam int HOLD_LEN   = 300;    // long receiver hold-off
   localparam int SETTLE     = 4;      // pause after the last result before a register write

   // Register indexes that the block does not implement
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE3 = 2'd3;

   typedef struct {
      logic [PCT_W-1:0] percent;
      logic [SUM_W-1:0] total;
   } reading_t;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [9:0] raw_sample
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [6:0] percent_now, [16:7] window_sum
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [RAW_W-1:0]      csr_data;

   // Predictor state: calibration mirror and the averaging window
   logic [RAW_W-1:0]      dry_cfg;
   logic [RAW_W-1:0]      wet_cfg;
   logic [PCT_W-1:0]      window_ring [WINDOW];
   int                    ring_slot;
   int                    ring_total;

   reading_t              pending_readings [$];
   int                    error_count;
   int                    idle_cycles;

   // Receiver control
   int                    hold_cnt;
   bit                    rx_random;
   bit                    rx_state;
   int                    rx_left;

   moisture_scale_moving_average #(
      .WINDOW(WINDOW)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Map a raw reading onto 0..100 between the calibration points
   function automatic logic [PCT_W-1:0] scale_to_percent(logic [RAW_W-1:0] raw);
      bit num_neg;
      bit den_neg;
      int num_mag;
      int den_mag;
      int quot;
      num_neg = raw < dry_cfg;
      num_mag = num_neg ? int'(dry_cfg) - int'(raw) : int'(raw) - int'(dry_cfg);
      den_neg = wet_cfg < dry_cfg;
      den_mag = den_neg ? int'(dry_cfg) - int'(wet_cfg) : int'(wet_cfg) - int'(dry_cfg);
      if (den_mag == 0) return '0;
      quot = (num_mag * PctFull) / den_mag;
      if (quot == 0 || num_neg != den_neg) return '0;
      return (quot > PctFull) ? PCT_W'(PctFull) : PCT_W'(quot);
   endfunction

   // Replace the oldest window entry and return the expected reading
   function automatic reading_t advance_window(logic [RAW_W-1:0] raw);
      reading_t r;
      r.percent = scale_to_percent(raw);
      ring_total = ring_total - int'(window_ring[ring_slot]) + int'(r.percent);
      window_ring[ring_slot] = r.percent;
      ring_slot = (ring_slot + 1 >= WINDOW) ? 0 : ring_slot + 1;
      r.total = (ring_total > SumMax) ? SUM_W'(SumMax) : SUM_W'(ring_total);
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // Offer one request and hold it until accepted; valid stays high for the caller
   task automatic send_sample(logic [RAW_W-1:0] raw);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(raw);
      do @(posedge clock); while (!(req_tvalid && req_tready));
      pending_readings.push_back(advance_window(raw));
   endtask

   task automatic pause_sender(int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stop sending and wait until every expected result has arrived
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   task automatic program_register(logic [CSR_IDX_W-1:0] idx, logic [RAW_W-1:0] value);
      drain_results();
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      case (idx)
         CSR_DRY: dry_cfg = value;
         CSR_WET: wet_cfg = value;
         default: ;
      endcase
   endtask

   task automatic set_calibration(logic [RAW_W-1:0] dry, logic [RAW_W-1:0] wet);
      program_register(CSR_DRY, dry);
      program_register(CSR_WET, wet);
   endtask

   // Default calibration: extremes of the reading and both clamps
   task automatic test_reset_defaults();
      send_sample(10'd0);
      send_sample(10'd1023);
      send_sample(10'd300);
      send_sample(10'd600);
      send_sample(10'd450);
      send_sample(10'd299);
      send_sample(10'd601);
   endtask

   // Equal points give zero; extreme points in both directions
   task automatic test_calibration_extremes();
      set_calibration(10'd512, 10'd512);
      send_sample(10'd0);
      send_sample(10'd512);
      send_sample(10'd1023);
      set_calibration(10'd0, 10'd1023);
      send_sample(10'd0);
      send_sample(10'd1023);
      send_sample(10'd511);
      set_calibration(10'd1023, 10'd0);
      send_sample(10'd0);
      send_sample(10'd1023);
      set_calibration(10'd0, 10'd0);
      send_sample(10'd700);
      set_calibration(10'd1023, 10'd1023);
      send_sample(10'd1023);
   endtask

   // Writes to unimplemented indexes must leave the calibration alone
   task automatic test_unknown_index();
      set_calibration(10'd200, 10'd800);
      program_register(CSR_SPARE2, 10'h3FF);
      program_register(CSR_SPARE3, 10'h155);
      send_sample(10'd500);
      send_sample(10'd800);
   endtask

   // Hold the receiver off while the sender keeps offering, then pause to drain
   task automatic test_backpressure();
      drain_results();
      hold_cnt = HOLD_LEN;
      for (int i = 0; i < 12; i++) send_sample(10'($urandom_range(1023, 0)));
      drain_results();
   endtask

   // Random phases: each with its own calibration, sender gaps and receiver pattern
   task automatic test_random_phases(int per_phase);
      int lo;
      int hi;
      int burst_left;
      bit gaps_on;
      logic [RAW_W-1:0] dry;
      logic [RAW_W-1:0] wet;
      logic [RAW_W-1:0] raw;
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin dry = 10'($urandom_range(1023, 512)); wet = 10'($urandom_range(511, 0)); end
            1: begin dry = 10'($urandom_range(511, 0)); wet = 10'($urandom_range(1023, 512)); end
            2: begin dry = 10'($urandom_range(1023, 0)); wet = dry; end
            3: begin dry = 10'd1023; wet = 10'd0; end
            4: begin dry = 10'd0; wet = 10'($urandom_range(40, 1)); end
            default: begin dry = 10'($urandom()); wet = 10'($urandom()); end
         endcase
         set_calibration(dry, wet);
         rx_random  = (phase % 3) != 0;
         gaps_on    = (phase % 2) == 0;
         burst_left = $urandom_range(12, 1);
         lo = ((dry < wet) ? int'(dry) : int'(wet)) - 16;
         hi = ((dry < wet) ? int'(wet) : int'(dry)) + 16;
         if (lo < 0) lo = 0;
         if (hi > 1023) hi = 1023;
         for (int n = 0; n < per_phase; n++) begin
            // mostly readings around the calibrated span, some anywhere
            if ($urandom_range(9, 0) < 6) raw = 10'($urandom_range(hi, lo));
            else raw = 10'($urandom());
            send_sample(raw);
            if (gaps_on && --burst_left <= 0) begin
               pause_sender($urandom_range(25, 1));
               burst_left = $urandom_range(12, 1);
            end
         end
      end
      rx_random = 1'b0;
   endtask

   // Receiver: long hold-off when asked, else always ready or a random stall pattern
   initial begin
      rsp_tready <= 1'b0;
      rx_state = 1'b1;
      rx_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_cnt > 0) begin
            rsp_tready <= 1'b0;
            hold_cnt--;
         end else if (!rx_random) begin
            rsp_tready <= 1'b1;
         end else begin
            if (rx_left == 0) begin
               rx_state = ~rx_state;
               rx_left  = rx_state ? $urandom_range(15, 1) : $urandom_range(6, 1);
            end
            rx_left--;
            rsp_tready <= rx_state;
         end
      end
   end

   // Compare each result against the oldest expected reading
   always @(posedge clock) begin : check_results
      reading_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            report_mismatch("result with nothing pending, window_sum",
                            int'(rsp_tdata[PCT_W+SUM_W-1:PCT_W]), -1);
         end else begin
            want = pending_readings.pop_front();
            if (rsp_tdata[PCT_W-1:0] !== want.percent)
               report_mismatch("percent_now", int'(rsp_tdata[PCT_W-1:0]), int'(want.percent));
            if (rsp_tdata[PCT_W+SUM_W-1:PCT_W] !== want.total)
               report_mismatch("window_sum", int'(rsp_tdata[PCT_W+SUM_W-1:PCT_W]),
                               int'(want.total));
         end
      end
   end

   // Watchdog: end the run when no channel makes progress for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_DRY;
      csr_data   <= '0;
      error_count = 0;
      idle_cycles = 0;
      hold_cnt    = 0;
      rx_random   = 1'b0;
      dry_cfg     = RAW_W'(DryReset);
      wet_cfg     = RAW_W'(WetReset);
      ring_slot   = 0;
      ring_total  = 0;
      for (int i = 0; i < WINDOW; i++) window_ring[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_calibration_extremes();
      test_unknown_index();
      test_backpressure();
      test_random_phases(90);
      test_backpressure();

      drain_results();
      repeat (40) @(posedge clock);
      if (pending_readings.size() != 0)
         report_mismatch("results still pending at end", 0, pending_readings.size());
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> moisture_scale_moving_average.f
rtl/msma_pkg.sv
rtl/msma_ctrl.sv
rtl/msma_dpath.sv
rtl/moisture_scale_moving_average.sv
verif/moisture_scale_moving_average_tb.sv
